>>> rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, muted in reset
`define CHK_IMPLY(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, muted in reset
`define CHK_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/scalu_pkg.sv
package scalu_pkg;

  localparam int WordW = 32;
  localparam int OpW = 5;
  localparam int ShW = $clog2(WordW);
  localparam int BytesPerWord = 4;
  localparam int ByteSelBits = 2;

  localparam logic [OpW-1:0] OP_LOAD = 5'd0;
  localparam logic [OpW-1:0] OP_ADD = 5'd1;
  localparam logic [OpW-1:0] OP_AND = 5'd2;
  localparam logic [OpW-1:0] OP_BCNT = 5'd3;
  localparam logic [OpW-1:0] OP_BSUB = 5'd4;
  localparam logic [OpW-1:0] OP_CCNT1 = 5'd5;
  localparam logic [OpW-1:0] OP_CSUB0 = 5'd6;
  localparam logic [OpW-1:0] OP_CWORD = 5'd7;
  localparam logic [OpW-1:0] OP_DIFF = 5'd8;
  localparam logic [OpW-1:0] OP_DIV = 5'd9;
  localparam logic [OpW-1:0] OP_DUP = 5'd10;
  localparam logic [OpW-1:0] OP_GT = 5'd11;
  localparam logic [OpW-1:0] OP_MINT = 5'd12;
  localparam logic [OpW-1:0] OP_MUL = 5'd13;
  localparam logic [OpW-1:0] OP_NOT = 5'd14;
  localparam logic [OpW-1:0] OP_OR = 5'd15;
  localparam logic [OpW-1:0] OP_PROD = 5'd16;
  localparam logic [OpW-1:0] OP_REM = 5'd17;
  localparam logic [OpW-1:0] OP_REV = 5'd18;
  localparam logic [OpW-1:0] OP_SHL = 5'd19;
  localparam logic [OpW-1:0] OP_SHR = 5'd20;
  localparam logic [OpW-1:0] OP_SUB = 5'd21;
  localparam logic [OpW-1:0] OP_SUM = 5'd22;
  localparam logic [OpW-1:0] OP_WCNT = 5'd23;
  localparam logic [OpW-1:0] OP_WSUB = 5'd24;
  localparam logic [OpW-1:0] OP_XOR = 5'd25;
  localparam logic [OpW-1:0] OP_SETERR = 5'd26;
  localparam logic [OpW-1:0] OP_TESTERR = 5'd27;
  localparam logic [OpW-1:0] OP_CLRHALTERR = 5'd28;
  localparam logic [OpW-1:0] OP_SETHALTERR = 5'd29;
  localparam logic [OpW-1:0] OP_TESTHALTERR = 5'd30;

  typedef struct packed {
    logic [OpW-1:0] req_type;
    logic signed [31:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] top_a;
    logic signed [31:0] second_b;
    logic signed [31:0] third_c;
    logic error_flag;
    logic halt_on_error;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch request
    logic exec;      // simple op commit
    logic div_start; // load divider
    logic div_step;  // one quotient bit
    logic div_done;  // commit divide result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_div;
    logic div_last;
  } dp_sts_t;

endpackage

>>> rtl/scalu_ctrl.sv
module scalu_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic out_fire,
  input  scalu_pkg::dp_sts_t sts,
  output scalu_pkg::dp_cmd_t cmd,
  output logic in_ready,
  output logic out_valid
);
  import scalu_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DIV = 3'd2;
  localparam logic [2:0] S_FIN = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  logic [2:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.capture = in_fire;
    case (state)
      S_IDLE: begin
        if (in_fire) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (sts.is_div) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end else begin
          cmd.exec = 1'b1;
          state_next = S_OUT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.div_done = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_fire) state_next = in_fire ? S_EXEC : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready = (state == S_IDLE) || (state == S_OUT && out_fire);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

>>> rtl/scalu_dp.sv
module scalu_dp (
  input  logic clk,
  input  logic rst,
  input  scalu_pkg::req_t req,
  input  scalu_pkg::dp_cmd_t cmd,
  output scalu_pkg::dp_sts_t sts,
  output scalu_pkg::rsp_t rsp
);
  import scalu_pkg::*;

  logic [WordW-1:0] reg_a, reg_b, reg_c;
  logic err_flag, halt_err_flag;
  logic [OpW-1:0] op;
  logic [WordW-1:0] pv;

  // divider state
  logic [WordW-1:0] dv_q, dv_r, dv_d;
  logic [ShW-1:0] dv_cnt;
  logic dv_fault, dv_na, dv_nb, dv_rem;

  logic [WordW-1:0] a_next, b_next, c_next;
  logic err_next, herr_next;
  logic [WordW-1:0] shl_v, shr_v, prod_v;
  logic [WordW:0] trial;
  logic [WordW-1:0] r_sh;
  logic [WordW-1:0] q_res, r_res;
  localparam logic [WordW-1:0] SignBit = {1'b1, {(WordW-1){1'b0}}};
  localparam logic [WordW-1:0] AllOnes = '1;

  assign sts.is_div = (op == OP_DIV) || (op == OP_REM);
  assign sts.div_last = (dv_cnt == '0);

  assign shl_v = (reg_a >= WordW) ? '0 : (reg_b << reg_a[ShW-1:0]);
  assign shr_v = (reg_a >= WordW) ? '0 : (reg_b >> reg_a[ShW-1:0]);
  assign prod_v = reg_a * reg_b;

  always_comb begin
    a_next = reg_a;
    b_next = reg_b;
    c_next = reg_c;
    err_next = err_flag;
    herr_next = halt_err_flag;
    case (op)
      OP_LOAD: begin a_next = pv; b_next = reg_a; c_next = reg_b; end
      OP_ADD, OP_BSUB, OP_SUM: begin a_next = reg_b + reg_a; b_next = reg_c; end
      OP_AND: begin a_next = reg_a & reg_b; b_next = reg_c; end
      OP_BCNT: a_next = reg_a << ByteSelBits;
      OP_CCNT1: begin
        if (reg_b == '0 || reg_b > reg_a) err_next = 1'b1;
        a_next = reg_b; b_next = reg_c;
      end
      OP_CSUB0: begin
        if (reg_b >= reg_a) err_next = 1'b1;
        a_next = reg_b; b_next = reg_c;
      end
      OP_CWORD: begin
        if (!($signed(reg_a) > $signed(reg_b)) || ($signed(-reg_a) > $signed(reg_b)))
          err_next = 1'b1;
        a_next = reg_b; b_next = reg_c;
      end
      OP_DIFF, OP_SUB: begin a_next = reg_b - reg_a; b_next = reg_c; end
      OP_DUP: begin b_next = reg_a; c_next = reg_b; end
      OP_GT: begin
        a_next = {{(WordW-1){1'b0}}, $signed(reg_b) > $signed(reg_a)};
        b_next = reg_c;
      end
      OP_MINT: begin a_next = SignBit; b_next = reg_a; c_next = reg_b; end
      OP_MUL, OP_PROD: begin a_next = prod_v; b_next = reg_c; end
      OP_NOT: a_next = ~reg_a;
      OP_OR: begin a_next = reg_a | reg_b; b_next = reg_c; end
      OP_REV: begin a_next = reg_b; b_next = reg_a; end
      OP_SHL: begin a_next = shl_v; b_next = reg_c; end
      OP_SHR: begin a_next = shr_v; b_next = reg_c; end
      OP_WCNT: begin
        c_next = reg_b;
        b_next = {{(WordW-ByteSelBits){1'b0}}, reg_a[ByteSelBits-1:0]};
        a_next = reg_a >> ByteSelBits;
      end
      OP_WSUB: begin a_next = reg_a + (reg_b << ByteSelBits); b_next = reg_c; end
      OP_XOR: begin a_next = reg_a ^ reg_b; b_next = reg_c; end
      OP_SETERR: err_next = 1'b1;
      OP_TESTERR: begin
        a_next = {{(WordW-1){1'b0}}, ~err_flag}; b_next = reg_a; c_next = reg_b;
        err_next = 1'b0;
      end
      OP_CLRHALTERR: herr_next = 1'b0;
      OP_SETHALTERR: herr_next = 1'b1;
      OP_TESTHALTERR: begin
        a_next = {{(WordW-1){1'b0}}, halt_err_flag}; b_next = reg_a; c_next = reg_b;
      end
      default: ;
    endcase
  end

  // restoring divide on magnitudes, one bit per cycle
  assign r_sh = {dv_r[WordW-2:0], dv_q[WordW-1]};
  assign trial = {1'b0, r_sh} - {1'b0, dv_d};
  assign q_res = dv_na ^ dv_nb ? -dv_q : dv_q;
  assign r_res = dv_nb ? -dv_r : dv_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op <= req.req_type;
      pv <= WordW'(req.push_value);
    end
    if (cmd.div_start) begin
      dv_fault <= (reg_a == '0) || (reg_a == AllOnes && reg_b == SignBit);
      dv_na <= reg_a[WordW-1];
      dv_nb <= reg_b[WordW-1];
      dv_rem <= (op == OP_REM);
      dv_d <= reg_a[WordW-1] ? -reg_a : reg_a;
      dv_q <= reg_b[WordW-1] ? -reg_b : reg_b;
      dv_r <= '0;
      dv_cnt <= ShW'(WordW - 1);
    end else if (cmd.div_step) begin
      dv_cnt <= dv_cnt - 1'b1;
      if (!trial[WordW]) begin
        dv_r <= trial[WordW-1:0];
        dv_q <= {dv_q[WordW-2:0], 1'b1};
      end else begin
        dv_r <= r_sh;
        dv_q <= {dv_q[WordW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_a <= '0;
      reg_b <= '0;
      reg_c <= '0;
      err_flag <= 1'b0;
      halt_err_flag <= 1'b0;
    end else if (cmd.exec) begin
      reg_a <= a_next;
      reg_b <= b_next;
      reg_c <= c_next;
      err_flag <= err_next;
      halt_err_flag <= herr_next;
    end else if (cmd.div_done) begin
      if (dv_fault) err_flag <= 1'b1;
      else begin
        reg_a <= dv_rem ? r_res : q_res;
        reg_b <= reg_c;
      end
    end
  end

  assign rsp.top_a = 32'(reg_a);
  assign rsp.second_b = 32'(reg_b);
  assign rsp.third_c = 32'(reg_c);
  assign rsp.error_flag = err_flag;
  assign rsp.halt_on_error = halt_err_flag;
endmodule

>>> rtl/stack_cpu_alu_ops_core.sv
// evaluation-stack alu: each request beat runs one operation on the a/b/c
// stack and the error and halt-on-error flags, and returns one response beat
// with the registers and flags after it. simple operations pass through the
// execute state to the response; div and rem run on a one-bit-per-cycle
// restoring divider through the divide and finish states. a new request is
// taken in the cycle the response is taken, not before, so requests do not
// overlap. the response holds until taken.
module stack_cpu_alu_ops_core (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  scalu_pkg::req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output scalu_pkg::rsp_t out_data
);
  import scalu_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic in_fire, out_fire;

  // handshake completion on each side
  assign in_fire = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // sequencer: capture, execute or divide, then present response
  scalu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_fire(out_fire),
    .sts(sts), .cmd(cmd), .in_ready(in_ready), .out_valid(out_valid)
  );

  // stack registers, flags, operation logic and divider
  scalu_dp u_dp (
    .clk(clk), .rst(rst), .req(in_data), .cmd(cmd), .sts(sts), .rsp(out_data)
  );
endmodule

>>> rtl/scalu_checker.sv
`include "assert_macros.svh"
module scalu_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input scalu_pkg::rsp_t out_data
);
  // no new request while a response waits unless it is being taken
  `CHK_IMPLY(a_no_overrun, clk, rst, out_valid && !out_ready, !in_ready, "accepted over pending")
  // an accepted request yields no response in the very next cycle
  `CHK_NEXT(a_lat, clk, rst, in_valid && in_ready, !out_valid, "response too early")
  // response held while stalled
  `CHK_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "response changed")
  // no response appears when idle and nothing is requested
  `CHK_NEXT(a_idle, clk, rst, !out_valid && in_ready && !in_valid, !out_valid, "spurious response")
endmodule

bind stack_cpu_alu_ops_core scalu_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
